// File: rtl/binary_trie_longest_prefix_match_macros.svh
// assertion macros shared by the trie lookup block
`ifndef BINARY_TRIE_LONGEST_PREFIX_MATCH_MACROS_SVH
`define BINARY_TRIE_LONGEST_PREFIX_MATCH_MACROS_SVH

// same-cycle implication, quiet during reset
`define BLPM_ASSERT_IMPLY(lbl, ck, rn, a, b, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define BLPM_ASSERT_NEXT(lbl, ck, rn, a, b, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) \
        else $error(msg);

`endif

// File: rtl/blpm_pkg.sv
// types and constants of the trie lookup block
package blpm_pkg;

    localparam int NODES      = 1024;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(NODES);
    localparam int CNT_W      = $clog2(NODES + 1);
    localparam int LINK_W     = 2 * IDX_W;
    localparam int ENTRY_W    = VALUE_BITS + 1;
    localparam int ADDR_BITS  = 32;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [LINK_W-1:0]     link_t;
    typedef logic [ENTRY_W-1:0]    entry_t;
    typedef logic [VALUE_BITS-1:0] value_t;

    typedef struct packed {
        logic        opcode;
        logic [31:0] address;
        logic [5:0]  prefix_len;
        logic [31:0] route_value;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [31:0] match_value;
        logic        status;
    } res_t;

    // node memory accesses issued by the walker
    typedef struct packed {
        logic   link_we;
        idx_t   link_waddr;
        link_t  link_wdata;
        logic   entry_we;
        idx_t   entry_waddr;
        entry_t entry_wdata;
        idx_t   raddr;
    } mem_req_t;

endpackage

// File: rtl/binary_trie_longest_prefix_match.sv
// Longest prefix match over a unibit binary trie of 32-bit addresses. A command
// beat is taken when start is high and busy is low; its single result appears
// for exactly one cycle with done high and must be captured then, since there
// is no way to hold it off. A lookup visits 1 to 33 trie nodes, one per level, and
// an insert walks down to its prefix length p, or stops when the node pool is full.
// Busy stays high for the walk; the strobe comes in the cycle after, and the next
// command can be taken in that same cycle. A new command is not taken until the
// last one is done. The walk is paced by the dependent read of one trie node per
// level through the registered-read node memories. No clearing pass is needed
// after reset: nodes are zeroed as they are allocated.
`include "binary_trie_longest_prefix_match_macros.svh"

module binary_trie_longest_prefix_match (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  blpm_pkg::req_t request,
    output logic           busy,
    output logic           done,
    output blpm_pkg::res_t result
);

    blpm_pkg::mem_req_t mem;
    blpm_pkg::link_t    link_rdata;
    blpm_pkg::entry_t   entry_rdata;

    blpm_ram #(
        .WIDTH (blpm_pkg::LINK_W),
        .DEPTH (blpm_pkg::NODES)
    ) u_links (
        .clk   (clk),
        .we    (mem.link_we),
        .waddr (mem.link_waddr),
        .wdata (mem.link_wdata),
        .raddr (mem.raddr),
        .rdata (link_rdata)
    );

    blpm_ram #(
        .WIDTH (blpm_pkg::ENTRY_W),
        .DEPTH (blpm_pkg::NODES)
    ) u_entries (
        .clk   (clk),
        .we    (mem.entry_we),
        .waddr (mem.entry_waddr),
        .wdata (mem.entry_wdata),
        .raddr (mem.raddr),
        .rdata (entry_rdata)
    );

    blpm_walk u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .request     (request),
        .busy        (busy),
        .done        (done),
        .result      (result),
        .mem         (mem),
        .link_rdata  (link_rdata),
        .entry_rdata (entry_rdata)
    );

    `BLPM_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted beat did not raise busy")
    `BLPM_ASSERT_IMPLY(a_done_idle, clk, rst_n, done, !busy, "result strobe while still walking")
    `BLPM_ASSERT_IMPLY(a_found_ok, clk, rst_n, done && result.found, result.status == blpm_pkg::ST_OK, "lookup hit reported with pool full")

endmodule

// File: rtl/blpm_ram.sv
// simple dual-port ram, one write port and one registered read port
module blpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/blpm_walk.sv
// trie walker: sequencer for lookups and inserts over the node memories
module blpm_walk (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  blpm_pkg::req_t    request,
    output logic              busy,
    output logic              done,
    output blpm_pkg::res_t    result,
    output blpm_pkg::mem_req_t mem,
    input  blpm_pkg::link_t   link_rdata,
    input  blpm_pkg::entry_t  entry_rdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_INS  = 2'd2;

    localparam logic [5:0] MAX_DEPTH = 6'(blpm_pkg::ADDR_BITS);
    localparam int W = blpm_pkg::IDX_W;

    logic [1:0]       state_reg, state_next;
    blpm_pkg::idx_t   node_reg, node_next;
    logic [5:0]       depth_reg, depth_next;
    logic             fresh_reg, fresh_next;
    logic [31:0]      sh_reg, sh_next;
    logic [5:0]       plen_reg, plen_next;
    blpm_pkg::value_t value_reg, value_next;
    blpm_pkg::cnt_t   free_reg, free_next;
    logic             root_link_ok_reg, root_link_ok_next;
    logic             root_entry_ok_reg, root_entry_ok_next;
    logic             found_reg, found_next;
    logic [31:0]      match_reg, match_next;
    logic             status_reg, status_next;
    logic             done_reg, done_next;

    blpm_pkg::link_t  link_data;
    blpm_pkg::entry_t entry_data;
    blpm_pkg::idx_t   child;
    blpm_pkg::idx_t   new_idx;
    logic             dir;
    logic             no_root_link;
    logic             no_root_entry;

    // rows never written read as empty: fresh nodes and the untouched root
    assign no_root_link  = (node_reg == '0) && !root_link_ok_reg;
    assign no_root_entry = (node_reg == '0) && !root_entry_ok_reg;
    assign link_data  = (fresh_reg || no_root_link) ? '0 : link_rdata;
    assign entry_data = (fresh_reg || no_root_entry) ? '0 : entry_rdata;
    assign dir        = sh_reg[31];
    assign child      = dir ? link_data[2*W-1:W] : link_data[W-1:0];
    assign new_idx    = free_reg[W-1:0];

    always_comb
    begin
        state_next         = state_reg;
        node_next          = node_reg;
        depth_next         = depth_reg;
        fresh_next         = fresh_reg;
        sh_next            = sh_reg;
        plen_next          = plen_reg;
        value_next         = value_reg;
        free_next          = free_reg;
        root_link_ok_next  = root_link_ok_reg;
        root_entry_ok_next = root_entry_ok_reg;
        found_next         = found_reg;
        match_next         = match_reg;
        status_next        = status_reg;
        done_next          = 1'b0;
        mem                = '0;
        mem.raddr          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    node_next   = '0;
                    depth_next  = '0;
                    fresh_next  = 1'b0;
                    sh_next     = request.address;
                    plen_next   = (request.prefix_len > MAX_DEPTH) ? MAX_DEPTH
                                                                 : request.prefix_len;
                    value_next  = blpm_pkg::value_t'(request.route_value);
                    found_next  = 1'b0;
                    match_next  = '0;
                    status_next = blpm_pkg::ST_OK;
                    state_next  = (request.opcode == blpm_pkg::OP_INSERT) ? S_INS : S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (entry_data[blpm_pkg::ENTRY_W-1])
                begin
                    found_next = 1'b1;
                    match_next = 32'(entry_data[blpm_pkg::VALUE_BITS-1:0]);
                end
                if (depth_reg == MAX_DEPTH || child == '0)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    node_next  = child;
                    mem.raddr  = child;
                    depth_next = depth_reg + 6'd1;
                    sh_next    = {sh_reg[30:0], 1'b0};
                end
            end
            S_INS:
            begin
                if (depth_reg == plen_reg)
                begin
                    mem.entry_we    = 1'b1;
                    mem.entry_waddr = node_reg;
                    mem.entry_wdata = {1'b1, value_reg};
                    mem.link_we     = fresh_reg;
                    mem.link_waddr  = node_reg;
                    mem.link_wdata  = '0;
                    if (node_reg == '0)
                    begin
                        root_entry_ok_next = 1'b1;
                    end
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else if (child != '0)
                begin
                    node_next  = child;
                    mem.raddr  = child;
                    depth_next = depth_reg + 6'd1;
                    sh_next    = {sh_reg[30:0], 1'b0};
                end
                else if (free_reg == blpm_pkg::CNT_W'(blpm_pkg::NODES))
                begin
                    // pool exhausted: close the dangling fresh node and stop
                    mem.link_we    = fresh_reg;
                    mem.link_waddr = node_reg;
                    mem.link_wdata = '0;
                    status_next    = blpm_pkg::ST_FULL;
                    state_next     = S_IDLE;
                    done_next      = 1'b1;
                end
                else
                begin
                    mem.link_we     = 1'b1;
                    mem.link_waddr  = node_reg;
                    mem.link_wdata  = dir ? {new_idx, link_data[W-1:0]}
                                          : {link_data[2*W-1:W], new_idx};
                    mem.entry_we    = 1'b1;
                    mem.entry_waddr = new_idx;
                    mem.entry_wdata = '0;
                    if (node_reg == '0)
                    begin
                        root_link_ok_next = 1'b1;
                    end
                    node_next  = new_idx;
                    fresh_next = 1'b1;
                    free_next  = free_reg + 1'b1;
                    depth_next = depth_reg + 6'd1;
                    sh_next    = {sh_reg[30:0], 1'b0};
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            free_reg          <= blpm_pkg::CNT_W'(1);
            root_link_ok_reg  <= 1'b0;
            root_entry_ok_reg <= 1'b0;
            done_reg          <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            free_reg          <= free_next;
            root_link_ok_reg  <= root_link_ok_next;
            root_entry_ok_reg <= root_entry_ok_next;
            done_reg          <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        depth_reg  <= depth_next;
        fresh_reg  <= fresh_next;
        sh_reg     <= sh_next;
        plen_reg   <= plen_next;
        value_reg  <= value_next;
        found_reg  <= found_next;
        match_reg  <= match_next;
        status_reg <= status_next;
    end

    assign busy               = (state_reg != S_IDLE);
    assign done               = done_reg;
    assign result.found       = found_reg;
    assign result.match_value = match_reg;
    assign result.status      = status_reg;

endmodule
